/* hw/rtl/crc32_frc_pkg.sv */
// Shared definitions for the CRC-32 framed record checker.
// Record layout, status and register codes, CRC byte step.
// No dependencies.
package crc32_frc_pkg;

  // Record layout
  localparam int unsigned HEADER_BYTES = 12;
  localparam int unsigned POS_W        = 17;
  localparam logic [POS_W-1:0] POS_MAX = {POS_W{1'b1}};

  // CRC-32, reflected form
  localparam logic [31:0] CRC_POLY = 32'hEDB8_8320;
  localparam logic [31:0] CRC_ONES = 32'hFFFF_FFFF;

  // Configuration reset values
  localparam logic [31:0] MAGIC_RESET   = 32'h5347_4846;
  localparam logic [15:0] VERSION_RESET = 16'd1;
  localparam logic [15:0] LENGTH_RESET  = 16'd19;

  // Port widths
  localparam int unsigned STATUS_W   = 3;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 32;
  localparam int unsigned M_DATA_W   = 72;

  // Result status codes
  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 3'd0,
    ST_BAD_MAGIC = 3'd1,
    ST_BAD_VER   = 3'd2,
    ST_BAD_LEN   = 3'd3,
    ST_BAD_CRC   = 3'd4,
    ST_SHORT     = 3'd5
  } status_t;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MAGIC   = 2'd0,
    REG_VERSION = 2'd1,
    REG_LENGTH  = 2'd2,
    REG_UNUSED  = 2'd3
  } cfg_reg_t;

  // One result transaction
  typedef struct packed {
    logic [31:0] stored_crc;
    logic [31:0] computed_crc;
    status_t     status;
  } result_t;

  // Advance the CRC by one byte, eight bit steps unrolled
  function automatic logic [31:0] crc32_byte(input logic [31:0] crc_in,
                                             input logic [7:0]  data);
    logic [31:0] c;
    c = crc_in ^ {24'd0, data};
    for (int k = 0; k < 8; k++) begin
      c = (c >> 1) ^ (CRC_POLY & {32{c[0]}});
    end
    return c;
  endfunction

endpackage

/* hw/rtl/crc32_framed_record_checker_core.sv */
// Top level of the CRC-32 framed record checker.
// Depends on crc32_frc_pkg for layout constants, codes and the CRC step.
//
// Usage:
//   Records enter on the s_ stream one byte per transaction, header first:
//   4-byte magic, 16-bit version, 16-bit payload length, 32-bit stored CRC,
//   all little-endian, then the payload. s_tlast marks the final byte.
//   The byte carrying s_tlast produces one result transaction on the m_
//   stream (status, computed CRC, stored CRC); other bytes produce none.
//   A record that ends inside the header reports too short; otherwise status
//   gives the first failing check: magic, version, length, then a payload
//   shorter than configured, then CRC mismatch.
//   Throughput is one byte per cycle while s_tready is high: the unrolled
//   byte-wide CRC step and the header compares sit between the input
//   handshake and the record state registers. The result register is
//   backed by one skid entry, so bytes keep flowing while a result waits;
//   s_tready drops only when both entries are full. The cfg_ port writes
//   magic, version and payload length; write it only while no record is in
//   flight. Synchronous reset restores register defaults, clears the record
//   state and empties the output stage.
module crc32_framed_record_checker_core
  import crc32_frc_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  // Configuration write port
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  // Input byte stream
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [7:0]            s_tdata,   // [7:0] data_byte
  input  logic                  s_tlast,   // end_of_record
  // Result stream
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [M_DATA_W-1:0]   m_tdata    // [2:0] status, [34:3] computed_crc,
                                           // [66:35] stored_crc, [71:67] zero
);

  // Configuration registers
  logic [31:0] magic_word;
  logic [15:0] format_version;
  logic [15:0] payload_length;

  // Record state
  logic [POS_W-1:0] byte_position;
  logic [31:0]      crc_register;
  logic [31:0]      header_shift;
  logic [31:0]      captured_crc;
  logic             magic_match;
  logic             version_match;
  logic             length_match;

  // Next record state
  logic [POS_W-1:0] byte_position_next;
  logic [31:0]      crc_register_next;
  logic [31:0]      header_shift_next;
  logic [31:0]      captured_crc_next;
  logic             magic_match_next;
  logic             version_match_next;
  logic             length_match_next;

  // Output stage
  logic    out_valid;
  result_t out_data;
  logic    skid_valid;
  result_t skid_data;

  logic    in_xact;
  logic    out_xact;
  logic    in_header;
  logic    in_payload;
  logic    end_short;
  logic [POS_W-1:0] pay_pos;
  logic [POS_W-1:0] end_pay_pos;
  status_t status_next;
  result_t result_next;

  assign in_xact  = s_tvalid && s_tready;
  assign out_xact = out_valid && m_tready;
  assign s_tready = !skid_valid;

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      magic_word     <= MAGIC_RESET;
      format_version <= VERSION_RESET;
      payload_length <= LENGTH_RESET;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_MAGIC:   magic_word     <= cfg_data;
        REG_VERSION: format_version <= cfg_data[15:0];
        REG_LENGTH:  payload_length <= cfg_data[15:0];
        REG_UNUSED:  ;
        default:     ;
      endcase
    end
  end

  // Decode the byte position of the current transaction
  assign in_header  = byte_position < POS_W'(HEADER_BYTES);
  assign pay_pos    = byte_position - POS_W'(HEADER_BYTES);
  assign in_payload = !in_header && (pay_pos < {1'b0, payload_length});

  // Update header capture, CRC and position for one byte
  always_comb begin
    header_shift_next  = header_shift;
    magic_match_next   = magic_match;
    version_match_next = version_match;
    length_match_next  = length_match;
    captured_crc_next  = captured_crc;
    crc_register_next  = crc_register;
    if (in_header) begin
      header_shift_next = {s_tdata, header_shift[31:8]};
      if (byte_position == POS_W'(3)) begin
        magic_match_next = (header_shift_next == magic_word);
      end else if (byte_position == POS_W'(5)) begin
        version_match_next = (header_shift_next[31:16] == format_version);
      end else if (byte_position == POS_W'(7)) begin
        length_match_next = (header_shift_next[31:16] == payload_length);
      end else if (byte_position >= POS_W'(8)) begin
        unique case (byte_position[1:0])
          2'd0:    captured_crc_next[7:0]   = s_tdata;
          2'd1:    captured_crc_next[15:8]  = s_tdata;
          2'd2:    captured_crc_next[23:16] = s_tdata;
          2'd3:    captured_crc_next[31:24] = s_tdata;
          default: ;
        endcase
      end
    end else if (in_payload) begin
      crc_register_next = crc32_byte(crc_register, s_tdata);
    end
    if (byte_position != POS_MAX) begin
      byte_position_next = byte_position + POS_W'(1);
    end else begin
      byte_position_next = byte_position;
    end
  end

  // Judge the record on its final byte
  assign end_pay_pos = byte_position_next - POS_W'(HEADER_BYTES);
  assign end_short   = end_pay_pos < {1'b0, payload_length};

  always_comb begin
    priority if (byte_position_next < POS_W'(HEADER_BYTES)) begin
      status_next = ST_SHORT;
    end else if (!magic_match_next) begin
      status_next = ST_BAD_MAGIC;
    end else if (!version_match_next) begin
      status_next = ST_BAD_VER;
    end else if (!length_match_next) begin
      status_next = ST_BAD_LEN;
    end else if (end_short) begin
      status_next = ST_SHORT;
    end else if ((crc_register_next ^ CRC_ONES) != captured_crc_next) begin
      status_next = ST_BAD_CRC;
    end else begin
      status_next = ST_OK;
    end
  end

  assign result_next.status       = status_next;
  assign result_next.computed_crc = crc_register_next ^ CRC_ONES;
  assign result_next.stored_crc   = captured_crc_next;

  // Advance record state; clear it after the final byte
  always_ff @(posedge clk) begin
    if (rst || (in_xact && s_tlast)) begin
      byte_position <= '0;
      crc_register  <= CRC_ONES;
      header_shift  <= '0;
      captured_crc  <= '0;
      magic_match   <= 1'b0;
      version_match <= 1'b0;
      length_match  <= 1'b0;
    end else if (in_xact) begin
      byte_position <= byte_position_next;
      crc_register  <= crc_register_next;
      header_shift  <= header_shift_next;
      captured_crc  <= captured_crc_next;
      magic_match   <= magic_match_next;
      version_match <= version_match_next;
      length_match  <= length_match_next;
    end
  end

  // Hold results in the output register, spill into the skid entry
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else begin
      if (out_xact) begin
        out_valid  <= skid_valid;
        skid_valid <= 1'b0;
      end
      if (in_xact && s_tlast) begin
        if (!out_valid || m_tready) begin
          out_valid <= 1'b1;
        end else begin
          skid_valid <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_xact && skid_valid) begin
      out_data <= skid_data;
    end else if (in_xact && s_tlast && (!out_valid || m_tready)) begin
      out_data <= result_next;
    end
    if (in_xact && s_tlast && out_valid && !m_tready) begin
      skid_data <= result_next;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {5'd0, out_data.stored_crc, out_data.computed_crc, out_data.status};

endmodule
